// ===== rtl/core/id_allocator_recycle_fifo_defines.svh =====
// assertion macros used by the allocator checker
`ifndef ID_ALLOCATOR_RECYCLE_FIFO_DEFINES_SVH
`define ID_ALLOCATOR_RECYCLE_FIFO_DEFINES_SVH

// clocked property, disabled while reset is low
`define IDA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// a signal holds over the next cycle whenever cond is seen
`define IDA_ASSERT_HELD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== rtl/core/idalloc_pkg.sv =====
`default_nettype none

package idalloc_pkg;

    // id space and field widths
    localparam int ID_BITS_DEF = 16;
    localparam int FIELD_W     = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;

    // bitmap is stored as words of 2**WORD_LOG bits
    localparam int WORD_LOG = 4;
    localparam int WORD_W   = 1 << WORD_LOG;

    localparam logic [FIELD_W-1:0] START_ID_RESET = 16'd1;
    localparam logic [FIELD_W-1:0] ID_NONE        = 16'hFFFF;

    // request kinds, anything else acts as a query
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT    = 2'd2;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QRD,
        ST_BMRD,
        ST_SCAN,
        ST_HIT,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/idalloc_ram.sv =====
`default_nettype none

module idalloc_ram #(
    parameter int WIDTH = idalloc_pkg::WORD_W,
    parameter int DEPTH = idalloc_pkg::WORD_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/id_allocator_recycle_fifo.sv =====
// ID allocator over a space of 2**ID_BITS ids; the top id is never handed out and
// doubles as the exhausted code. Allocate first reuses the oldest released id from a
// recycle FIFO, otherwise it does a next-fit scan of the in-use bitmap. The bitmap lives
// in a RAM of 16-bit words and the FIFO in a second RAM, both with registered reads.
// Steps: release and query are accepted, then do one bitmap read-modify-write; an
// allocate from the FIFO does a FIFO read, then the bitmap read-modify-write; an
// allocate by scan reads one bitmap word per cycle, passing over at most 2**ID_BITS/16
// words before the hit, then does the read-modify-write of the hit word; a scan that
// finds the space full reports exhausted.
// A result waits in an output register while the next item is already taken. After
// reset the bitmap is swept clear, one word a cycle over all 2**ID_BITS/16 words (4096 at
// 16 bits); input is stalled during the sweep, configuration writes are taken anytime.
`default_nettype none

module id_allocator_recycle_fifo #(
    parameter int ID_BITS = idalloc_pkg::ID_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // request channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [idalloc_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [idalloc_pkg::FIELD_W-1:0]      i_id,
    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic      [idalloc_pkg::FIELD_W-1:0]      o_result_id,
    output logic      [idalloc_pkg::STATUS_W-1:0]     o_status,
    output logic      [idalloc_pkg::FIELD_W-1:0]      o_live_count,
    // start id register
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [idalloc_pkg::FIELD_W-1:0]      i_cfg_data
);

    localparam int WL       = idalloc_pkg::WORD_LOG;
    localparam int WW       = idalloc_pkg::WORD_W;
    localparam int FW       = idalloc_pkg::FIELD_W;
    localparam int SW       = idalloc_pkg::STATUS_W;
    localparam int ID_SPACE = 1 << ID_BITS;
    localparam int NWORDS   = ID_SPACE >> WL;
    localparam int WA_W     = (ID_BITS > WL) ? ID_BITS - WL : 1;
    localparam logic [WA_W-1:0] LAST_W   = WA_W'(NWORDS - 1);
    localparam logic [WW-1:0]   WORD_ALL = '1;

    // lowest set bit of a bitmap word
    function automatic logic [WL-1:0] lowest_set(input logic [WW-1:0] v);
        logic [WL-1:0] pos;
        pos = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = WL'(i);
            end
        end
        return pos;
    endfunction

    idalloc_pkg::t_state r_state, n_state;

    logic [idalloc_pkg::KIND_W-1:0] r_kind;
    logic [FW-1:0]                  r_id;
    logic [SW-1:0]                  r_rsp_status;
    logic [WW-1:0]                  r_word;
    logic [WA_W-1:0]                r_clr_addr;
    logic [ID_BITS-1:0]             r_next_id;
    logic [ID_BITS-1:0]             r_live, n_live;
    logic [ID_BITS-1:0]             r_head, r_tail;
    logic [ID_BITS:0]               r_fill;

    // scan issue and check stages
    logic [WA_W-1:0] r_iss_addr, r_chk_addr;
    logic            r_iss_phase, r_chk_phase;
    logic            r_iss_more, r_chk_valid;

    logic          r_out_valid;
    logic [FW-1:0] r_out_id;
    logic [SW-1:0] r_out_status;
    logic [FW-1:0] r_out_live;

    // memory ports
    logic               bm_we, bm_re;
    logic [WA_W-1:0]    bm_waddr, bm_raddr;
    logic [WW-1:0]      bm_wdata, bm_rdata;
    logic               q_we, q_re;
    logic [ID_BITS-1:0] q_rdata;

    logic            in_accept, out_free, fill_nz, id_in_range, is_alloc, is_rel;
    logic            commit, rsp_load, bit_old, q_push;
    logic [WW-1:0]   word_src, bit_sel, scan_mask, scan_free;
    logic [WL-1:0]   scan_pos, nib;
    logic [WA_W-1:0] nw;
    logic            scan_hit, scan_empty;
    logic [SW-1:0]   c_status;
    logic [ID_BITS-1:0] id_low, scan_found;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fill_nz     = (r_fill != '0);
    assign id_low      = i_id[ID_BITS-1:0];
    assign id_in_range = ((i_id >> ID_BITS) == '0);
    assign is_alloc    = (r_kind == idalloc_pkg::KIND_ALLOC);
    assign is_rel      = (r_kind == idalloc_pkg::KIND_RELEASE);

    // word and bit where the next-fit pointer sits
    assign nw  = WA_W'(r_next_id >> WL);
    assign nib = r_next_id[WL-1:0];

    // candidate bits of the checked word: upward pass, then wrap pass
    always_comb begin
        scan_mask = '0;
        if (!r_chk_phase) begin
            if (r_chk_addr > nw) begin
                scan_mask = WORD_ALL;
            end else if (r_chk_addr == nw) begin
                scan_mask = WORD_ALL << nib;
            end
            if (r_chk_addr == LAST_W) begin
                scan_mask[WW-1] = 1'b0;
            end
        end else begin
            if (r_chk_addr < nw) begin
                scan_mask = WORD_ALL;
            end else if (r_chk_addr == nw) begin
                scan_mask = ~(WORD_ALL << nib);
            end
            if (r_chk_addr == '0) begin
                scan_mask[0] = 1'b0;
            end
        end
    end

    assign scan_free  = ~bm_rdata & scan_mask;
    assign scan_pos   = lowest_set(scan_free);
    assign scan_hit   = r_chk_valid && (|scan_free);
    assign scan_empty = r_chk_valid && !(|scan_free) && !r_iss_more;
    assign scan_found = ID_BITS'({r_chk_addr, scan_pos});

    // read-modify-write of the bitmap word holding r_id
    assign word_src = (r_state == idalloc_pkg::ST_HIT) ? r_word : bm_rdata;
    assign bit_sel  = WW'(1) << r_id[WL-1:0];
    assign bit_old  = |(word_src & bit_sel);
    assign q_push   = commit && is_rel && bit_old && !r_fill[ID_BITS];

    always_comb begin
        if (is_alloc || bit_old) begin
            c_status = idalloc_pkg::STATUS_DONE;
        end else begin
            c_status = idalloc_pkg::STATUS_ABSENT;
        end
    end

    always_comb begin
        n_live = r_live;
        if (commit && is_alloc && !bit_old) begin
            n_live = r_live + 1'b1;
        end else if (commit && is_rel && bit_old) begin
            n_live = r_live - 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            idalloc_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_W) begin
                    n_state = idalloc_pkg::ST_IDLE;
                end
            end
            idalloc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_kind == idalloc_pkg::KIND_ALLOC) begin
                        n_state = fill_nz ? idalloc_pkg::ST_QRD : idalloc_pkg::ST_SCAN;
                    end else begin
                        n_state = id_in_range ? idalloc_pkg::ST_BMRD : idalloc_pkg::ST_RESP;
                    end
                end
            end
            idalloc_pkg::ST_QRD: begin
                n_state = idalloc_pkg::ST_BMRD;
            end
            idalloc_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    n_state = idalloc_pkg::ST_HIT;
                end else if (scan_empty) begin
                    n_state = idalloc_pkg::ST_RESP;
                end
            end
            idalloc_pkg::ST_BMRD, idalloc_pkg::ST_HIT, idalloc_pkg::ST_RESP: begin
                if (out_free) begin
                    n_state = idalloc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = idalloc_pkg::ST_CLEAR;
            end
        endcase
    end

    // memory control and commit strobes
    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = WA_W'(r_id[ID_BITS-1:0] >> WL);
        bm_wdata = is_alloc ? (word_src | bit_sel) : (word_src & ~bit_sel);
        bm_re    = 1'b0;
        bm_raddr = WA_W'(id_low >> WL);
        q_re     = 1'b0;
        commit   = 1'b0;
        rsp_load = 1'b0;
        case (r_state)
            idalloc_pkg::ST_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = r_clr_addr;
                bm_wdata = '0;
            end
            idalloc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_kind == idalloc_pkg::KIND_ALLOC) begin
                        q_re = fill_nz;
                    end else begin
                        bm_re = 1'b1;
                    end
                end
            end
            idalloc_pkg::ST_QRD: begin
                bm_re    = 1'b1;
                bm_raddr = WA_W'(q_rdata >> WL);
            end
            idalloc_pkg::ST_SCAN: begin
                bm_re    = r_iss_more;
                bm_raddr = r_iss_addr;
            end
            idalloc_pkg::ST_BMRD, idalloc_pkg::ST_HIT: begin
                commit = out_free;
                bm_we  = out_free && (is_alloc || (is_rel && bit_old));
            end
            idalloc_pkg::ST_RESP: begin
                rsp_load = out_free;
            end
            default: begin
                bm_we = 1'b0;
            end
        endcase
    end

    assign q_we = q_push;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= idalloc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_next_id   <= ID_BITS'(idalloc_pkg::START_ID_RESET);
            r_live      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_iss_addr  <= '0;
            r_iss_phase <= 1'b0;
            r_iss_more  <= 1'b0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (r_state == idalloc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // next-fit pointer follows a start id write, or a scan hit
            if (i_cfg_valid) begin
                r_next_id <= i_cfg_data[ID_BITS-1:0];
            end else if (commit && r_state == idalloc_pkg::ST_HIT) begin
                r_next_id <= r_id[ID_BITS-1:0] + 1'b1;
            end
            // recycle fifo pointers
            if (r_state == idalloc_pkg::ST_QRD) begin
                r_head <= r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
            if (q_push) begin
                r_tail <= r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end
            // scan word issue
            if (in_accept && i_kind == idalloc_pkg::KIND_ALLOC && !fill_nz) begin
                r_iss_addr  <= nw;
                r_iss_phase <= 1'b0;
                r_iss_more  <= 1'b1;
                r_chk_valid <= 1'b0;
            end else if (r_state == idalloc_pkg::ST_SCAN) begin
                r_chk_valid <= r_iss_more;
                if (r_iss_more) begin
                    if (!r_iss_phase && r_iss_addr == LAST_W) begin
                        r_iss_phase <= 1'b1;
                        r_iss_addr  <= '0;
                    end else if (r_iss_phase && r_iss_addr == nw) begin
                        r_iss_more <= 1'b0;
                    end else begin
                        r_iss_addr <= r_iss_addr + 1'b1;
                    end
                end
            end
            // output register
            if (commit || rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind       <= i_kind;
            r_id         <= i_id;
            r_rsp_status <= idalloc_pkg::STATUS_ABSENT;
        end
        if (r_state == idalloc_pkg::ST_QRD) begin
            r_id <= FW'(q_rdata);
        end
        if (r_state == idalloc_pkg::ST_SCAN) begin
            r_chk_addr  <= r_iss_addr;
            r_chk_phase <= r_iss_phase;
            if (scan_hit) begin
                r_word <= bm_rdata;
                r_id   <= FW'(scan_found);
            end else if (scan_empty) begin
                r_id         <= idalloc_pkg::ID_NONE;
                r_rsp_status <= idalloc_pkg::STATUS_EXHAUSTED;
            end
        end
        if (commit) begin
            r_out_id     <= r_id;
            r_out_status <= c_status;
            r_out_live   <= FW'(n_live);
        end else if (rsp_load) begin
            r_out_id     <= r_id;
            r_out_status <= r_rsp_status;
            r_out_live   <= FW'(r_live);
        end
    end

    // in-use bitmap, one word per entry
    idalloc_ram #(
        .WIDTH (WW),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    // recycle fifo storage
    idalloc_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (ID_SPACE)
    ) u_recycle (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (r_id[ID_BITS-1:0]),
        .i_re    (q_re),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    assign o_in_stall   = (r_state != idalloc_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_result_id  = r_out_id;
    assign o_status     = r_out_status;
    assign o_live_count = r_out_live;
    assign o_cfg_ready  = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/core/idalloc_chk.sv =====
`default_nettype none
`include "id_allocator_recycle_fifo_defines.svh"

module idalloc_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_in_stall,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic [idalloc_pkg::FIELD_W-1:0]  o_result_id,
    input wire logic [idalloc_pkg::STATUS_W-1:0] o_status
);

    logic out_held, exh_out, none_id;

    assign out_held = o_out_valid && i_out_stall;
    assign exh_out  = o_out_valid && (o_status == idalloc_pkg::STATUS_EXHAUSTED);
    assign none_id  = (o_result_id == idalloc_pkg::ID_NONE);

    // a stalled result stays offered
    `IDA_ASSERT(a_out_valid_hold, i_clk, i_rst_n, out_held |=> o_out_valid, "result dropped")

    // a stalled result keeps its id
    `IDA_ASSERT_HELD(a_out_id_hold, i_clk, i_rst_n, out_held, o_result_id, "result id changed")

    // exhausted always carries the all-ones id
    `IDA_ASSERT(a_exhausted_id, i_clk, i_rst_n, exh_out |-> none_id, "exhausted without none id")

    // input held off while the bitmap sweep runs after reset
    `IDA_ASSERT(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n) |-> o_in_stall, "early input")

endmodule

bind id_allocator_recycle_fifo idalloc_chk u_idalloc_chk (.*);

`default_nettype wire
